FILE: rtl/mts_pkg.sv
package mts_pkg;

  localparam int VALUE_W = 32;
  localparam int WORD_W  = 34;

  typedef logic signed [VALUE_W-1:0] value_t;
  // stored word: plain value, or 2*value - old_max when the value raised the max
  typedef logic signed [WORD_W-1:0]  word_t;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_t;

endpackage

FILE: rtl/mts_mem.sv
module mts_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  mts_pkg::word_t        wr_data,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output mts_pkg::word_t        rd_data
);

  mts_pkg::word_t mem_q [DEPTH];
  mts_pkg::word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_q[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/max_tracking_stack.sv
// Max-tracking LIFO stack.
// Input channel (in_*): one item per operation. in_tuser is the mode (0 push,
// 1 pop), in_tdata[31:0] the signed value to push (ignored for a pop).
// Result channel (out_*): exactly one item per input item, in order, carrying
// the maximum after the operation, a max-valid flag, the entry count and an
// error code (0 ok, 1 pop from empty, 2 push to full). A refused operation
// leaves the stack unchanged and reports the unchanged maximum and count.
// Timing: a push, or any refused operation, reaches the result register in the
// cycle after accept; a pop of a held entry first reads the top word into the read
// register of the synchronous stack memory (state S_POP), then the result register.
// One item is in work at a time; in_tready is high when the controller is idle
// and the result register is empty or being drained in that same cycle.
// Pushes sustain 1 item/cycle while out_tready is high; a pop blocks new items in S_POP.
// No extra max storage: the maximum is folded into the stored words.
// Reset (rst_n low, synchronous) empties the stack and the result register;
// memory contents are not cleared, only entries below the count are read.
// A stalled receiver (out_tready low) holds the result and blocks new items.
module max_tracking_stack #(
  parameter int STACK_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // [31:0] push_value
  input  logic              in_tuser,   // [0] mode
  output logic              out_tvalid,
  input  logic              out_tready,
  // [31:0] max_value, [32] max_valid, [32+CNT_W:33] entry_count, then error_code
  output logic [((35 + $clog2(STACK_DEPTH + 1) + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int ADDR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int FIELDS_W = 35 + CNT_W;
  localparam int OUT_W    = ((FIELDS_W + 7) / 8) * 8;

  typedef enum logic {S_IDLE, S_POP} state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      sp_r, sp_nxt;
  mts_pkg::value_t       max_r, max_nxt;
  logic                  out_valid_r, out_valid_nxt;
  mts_pkg::value_t       out_max_r, out_max_nxt;
  logic                  out_mvalid_r, out_mvalid_nxt;
  logic [CNT_W-1:0]      out_cnt_r, out_cnt_nxt;
  mts_pkg::err_t         out_err_r, out_err_nxt;

  logic                  in_fire;
  logic                  is_full;
  logic                  is_empty;
  mts_pkg::value_t       push_val;
  mts_pkg::word_t        enc_word;
  mts_pkg::word_t        restore;
  logic                  wr_en;
  mts_pkg::word_t        wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  mts_pkg::word_t        rd_data;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign is_full   = (sp_r == CNT_W'(STACK_DEPTH));
  assign is_empty  = (sp_r == '0);
  assign push_val  = mts_pkg::value_t'(in_tdata);
  assign enc_word  = (mts_pkg::word_t'(push_val) <<< 1) - mts_pkg::word_t'(max_r);
  assign restore   = (mts_pkg::word_t'(max_r) <<< 1) - rd_data;
  assign rd_addr   = ADDR_W'(sp_r - CNT_W'(1));

  always_comb begin
    state_nxt      = state_r;
    sp_nxt         = sp_r;
    max_nxt        = max_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_err_nxt    = out_err_r;
    wr_en          = 1'b0;
    wr_data        = mts_pkg::word_t'(push_val);
    rd_en          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = mts_pkg::ERR_OK;
          if (in_tuser == mts_pkg::MODE_PUSH) begin
            if (is_full) begin
              out_err_nxt = mts_pkg::ERR_PUSH_FULL;
            end else begin
              wr_en  = 1'b1;
              sp_nxt = sp_r + CNT_W'(1);
              if (is_empty || push_val > max_r) begin
                max_nxt = push_val;
              end
              // only a new max above a held max is encoded
              if (!is_empty && push_val > max_r) begin
                wr_data = enc_word;
              end
            end
          end else if (is_empty) begin
            out_err_nxt = mts_pkg::ERR_POP_EMPTY;
          end else begin
            rd_en         = 1'b1;
            sp_nxt        = sp_r - CNT_W'(1);
            state_nxt     = S_POP;
            out_valid_nxt = 1'b0;
          end
        end
      end
      S_POP: begin
        // encoded word above the max: recover the previous max
        if (rd_data > mts_pkg::word_t'(max_r)) begin
          max_nxt = restore[mts_pkg::VALUE_W-1:0];
        end
        out_valid_nxt = 1'b1;
        out_err_nxt   = mts_pkg::ERR_OK;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_cnt_nxt    = sp_nxt;
    out_mvalid_nxt = (sp_nxt != '0);
    out_max_nxt    = (sp_nxt != '0) ? max_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sp_r         <= '0;
      max_r        <= '0;
      out_valid_r  <= 1'b0;
      out_max_r    <= '0;
      out_mvalid_r <= 1'b0;
      out_cnt_r    <= '0;
      out_err_r    <= mts_pkg::ERR_OK;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
      if (out_valid_nxt && !out_valid_r || out_valid_nxt && out_tready) begin
        out_max_r    <= out_max_nxt;
        out_mvalid_r <= out_mvalid_nxt;
        out_cnt_r    <= out_cnt_nxt;
        out_err_r    <= out_err_nxt;
      end
    end
  end

  mts_mem #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (sp_r[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_err_r, out_cnt_r, out_mvalid_r, out_max_r});

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_pop_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == mts_pkg::MODE_POP && !is_empty)
    |=> (state_r == S_POP && !out_valid_r && !in_tready))
    else $error("pop did not wait for memory read");

  a_mvalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_mvalid_r == (out_cnt_r != '0)))
    else $error("max_valid disagrees with count");

  a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r == mts_pkg::ERR_PUSH_FULL)
    |-> (out_cnt_r == CNT_W'(STACK_DEPTH)))
    else $error("full error with room left");

endmodule
